FILE: hw/rtl/wamm_pkg.sv
// Shared types, constants and control structures of the windowed average tracker.
package wamm_pkg;

	// Field widths fixed by the item formats.
	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 4;
	// A window of at most fifteen 16-bit samples needs four extra bits.
	localparam int SUM_W    = SAMPLE_W + WIN_W;

	// Defaults and reset values.
	localparam int                          RING_DEPTH_DEF = 8;
	localparam logic [WIN_W-1:0]            WINDOW_RESET   = 4'd8;
	localparam logic signed [SAMPLE_W-1:0]  MAX_RESET      = 16'sh0000;
	localparam logic signed [SAMPLE_W-1:0]  MIN_RESET      = 16'sh7FFF;

	// Input command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic                        command;
		logic signed [SAMPLE_W-1:0]  sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  maximum;
		logic signed [SAMPLE_W-1:0]  minimum;
		logic signed [SAMPLE_W-1:0]  average;
		logic                        average_valid;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_SIGN,
		ST_FINISH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic rd_issue;
		logic div_start;
		logic div_step;
		logic sign_fix;
		logic load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic fresh;
		logic issue_done;
		logic read_pending;
		logic div_done;
		logic out_free;
	} ctl_sts_t;

endpackage

FILE: hw/rtl/wamm_ctrl.sv
// Controller state machine that sequences accept, window sum, division and output.
module wamm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wamm_pkg::ctl_sts_t sts,
	output wamm_pkg::ctl_cmd_t cmd
);
	import wamm_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.is_clear || !sts.fresh) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_ACCUM;
					end
				end
			end
			ST_ACCUM: begin
				if (sts.issue_done && !sts.read_pending) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (sts.div_done) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and input stall.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_ACCUM: begin
				cmd.rd_issue  = !sts.issue_done;
				cmd.div_start = sts.issue_done && !sts.read_pending;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_SIGN: begin
				cmd.sign_fix = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/wamm_datapath.sv
// Datapath: sample ring, running extremes, window sum, serial divider and output register.
module wamm_datapath #(
	parameter int RING_DEPTH = wamm_pkg::RING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wamm_pkg::in_item_t         in_item,
	input  logic                       cfg_we,
	input  logic [wamm_pkg::WIN_W-1:0] cfg_wdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output wamm_pkg::out_item_t        out_item,
	input  wamm_pkg::ctl_cmd_t         cmd,
	output wamm_pkg::ctl_sts_t         sts
);
	import wamm_pkg::*;

	localparam int SLOT_W    = $clog2(RING_DEPTH);
	localparam int CNT_W     = $clog2(RING_DEPTH + 1);
	localparam int DIV_CNT_W = $clog2(SUM_W);

	// Sample ring memory and its registered read port.
	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_data_s1;
	logic                       rd_valid_s1;

	logic [WIN_W-1:0]            window_q;
	logic [SLOT_W-1:0]           write_slot_q;
	logic [CNT_W-1:0]            stored_count_q;
	logic signed [SAMPLE_W-1:0]  max_q;
	logic signed [SAMPLE_W-1:0]  min_q;
	logic signed [SAMPLE_W-1:0]  held_avg_q;
	logic                        fresh_q;
	logic [SLOT_W-1:0]           rd_ptr_q;
	logic [WIN_W-1:0]            remain_q;
	logic [WIN_W-1:0]            div_w_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic                        neg_q;
	logic [SUM_W-1:0]            mag_q;
	logic [WIN_W-1:0]            rem_q;
	logic [DIV_CNT_W-1:0]        div_cnt_q;
	logic                        out_valid_q;
	out_item_t                   out_q;

	logic [WIN_W-1:0]  w_eff;
	logic [CNT_W-1:0]  count_new;
	logic              fresh_now;
	logic              is_clear;
	logic [WIN_W:0]    trial;
	logic              trial_ge;
	logic [SUM_W-1:0]  avg_full;

	assign is_clear = (in_item.command == CMD_CLEAR);

	// Effective window: zero counts as one, capped at the ring depth.
	always_comb begin
		w_eff = window_q;
		if (window_q == '0) begin
			w_eff = WIN_W'(1);
		end
		if (int'(window_q) > RING_DEPTH) begin
			w_eff = WIN_W'(RING_DEPTH);
		end
	end

	// Fill count after this sample and whether it yields a fresh mean.
	always_comb begin
		count_new = stored_count_q;
		if (int'(stored_count_q) < RING_DEPTH) begin
			count_new = stored_count_q + CNT_W'(1);
		end
		fresh_now = (int'(count_new) >= int'(w_eff));
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Ring write on each accepted sample.
	always_ff @(posedge clk) begin
		if (cmd.accept && !is_clear) begin
			ring_mem[write_slot_q] <= in_item.sample;
		end
	end

	// Ring read, one entry per cycle.
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_data_s1 <= ring_mem[rd_ptr_q];
		end
	end

	// Ring bookkeeping and running extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q   <= '0;
			stored_count_q <= '0;
			max_q          <= MAX_RESET;
			min_q          <= MIN_RESET;
			fresh_q        <= 1'b0;
		end else if (cmd.accept) begin
			if (is_clear) begin
				max_q   <= MAX_RESET;
				min_q   <= MIN_RESET;
				fresh_q <= 1'b0;
			end else begin
				if (write_slot_q == SLOT_W'(RING_DEPTH - 1)) begin
					write_slot_q <= '0;
				end else begin
					write_slot_q <= write_slot_q + SLOT_W'(1);
				end
				stored_count_q <= count_new;
				if (in_item.sample > max_q) begin
					max_q <= in_item.sample;
				end
				if (in_item.sample < min_q) begin
					min_q <= in_item.sample;
				end
				fresh_q <= fresh_now;
			end
		end
	end

	// Window walk: read pointer steps back from the newest slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_issue;
			if (cmd.accept) begin
				remain_q <= w_eff;
			end else if (cmd.rd_issue) begin
				remain_q <= remain_q - WIN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_ptr_q <= write_slot_q;
			div_w_q  <= w_eff;
			sum_q    <= '0;
		end else begin
			if (cmd.rd_issue) begin
				if (rd_ptr_q == '0) begin
					rd_ptr_q <= SLOT_W'(RING_DEPTH - 1);
				end else begin
					rd_ptr_q <= rd_ptr_q - SLOT_W'(1);
				end
			end
			if (rd_valid_s1) begin
				sum_q <= sum_q + {{(SUM_W - SAMPLE_W){rd_data_s1[SAMPLE_W-1]}}, rd_data_s1};
			end
		end
	end

	// Restoring division of the sum magnitude, one quotient bit per cycle.
	assign trial    = {rem_q, mag_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, div_w_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q     <= sum_q[SUM_W-1];
			mag_q     <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(SUM_W - 1);
		end else if (cmd.div_step) begin
			if (trial_ge) begin
				rem_q <= WIN_W'(trial - {1'b0, div_w_q});
			end else begin
				rem_q <= WIN_W'(trial);
			end
			mag_q     <= {mag_q[SUM_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	// Restore the sign of the quotient, which truncates toward zero.
	assign avg_full = neg_q ? (~mag_q + SUM_W'(1)) : mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_avg_q <= '0;
		end else if (cmd.sign_fix) begin
			held_avg_q <= avg_full[SAMPLE_W-1:0];
		end
	end

	// Output register; it holds while the item is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.maximum       <= max_q;
			out_q.minimum       <= min_q;
			out_q.average       <= held_avg_q;
			out_q.average_valid <= fresh_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Status toward the controller.
	always_comb begin
		sts.is_clear     = is_clear;
		sts.fresh        = fresh_now;
		sts.issue_done   = (remain_q == '0);
		sts.read_pending = rd_valid_s1;
		sts.div_done     = (div_cnt_q == '0);
		sts.out_free     = !out_valid_q || !out_stall;
	end

endmodule

FILE: hw/rtl/windowed_average_min_max_tracker_core.sv
// Top level of the windowed average tracker with running maximum and minimum.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  in_item  (command, sample)
//   output   out        out_valid/out_stall  out_item (maximum, minimum, average, average_valid)
//   config   in         cfg_we               cfg_wdata (window_length)
//
// One item is worked at a time. A clear, or a sample that gives no fresh mean,
// goes straight to the output register; a sample with a fresh mean first passes
// the one-read-per-cycle ring walk over the window and the 20-step serial divider.
// Reset clears all control state; the ring memory is not cleared.
// A stalled output item holds; the block finishes its item into the output
// register as soon as that register is free.
module windowed_average_min_max_tracker_core #(
	parameter int RING_DEPTH = wamm_pkg::RING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  wamm_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output wamm_pkg::out_item_t        out_item,
	input  logic                       cfg_we,
	input  logic [wamm_pkg::WIN_W-1:0] cfg_wdata
);
	import wamm_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Sequencer.
	wamm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	wamm_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: dv/tb_windowed_average_min_max_tracker_core.sv
// Self-checking testbench for the windowed average tracker with running maximum and minimum.
module tb_windowed_average_min_max_tracker_core;
	import wamm_pkg::*;

	localparam int RING         = RING_DEPTH_DEF;
	localparam int SAMPLE_MAX   = 32767;
	localparam int SAMPLE_MIN   = -32768;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int RUN_LIMIT    = 5_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_item = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                cfg_we = 1'b0;
	logic [WIN_W-1:0]    cfg_wdata = '0;

	// Items waiting to be offered and results waiting to be seen.
	in_item_t            pending_readings[$];
	out_item_t           expected_summaries[$];

	// Idle and stall rates in percent, set per phase.
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  hold_requests = 0;
	int                  holds_started = 0;
	int                  hold_left = 0;
	int                  mismatch_count = 0;

	// Tracker state as the block should hold it.
	logic signed [SAMPLE_W-1:0] ring_copy [RING];
	int                         next_slot = 0;
	int                         filled = 0;
	logic signed [SAMPLE_W-1:0] peak_high = MAX_RESET;
	logic signed [SAMPLE_W-1:0] peak_low = MIN_RESET;
	logic signed [SAMPLE_W-1:0] last_mean = '0;
	int                         window_setting = WINDOW_RESET;

	windowed_average_min_max_tracker_core #(
		.RING_DEPTH(RING)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one item to the tracker state and return the summary it should produce.
	function automatic out_item_t track_reading(in_item_t item);
		out_item_t summary;
		int        span;
		int        total;
		int        pos;
		logic      fresh;
		fresh = 1'b0;
		if (item.command == CMD_CLEAR) begin
			peak_high = MAX_RESET;
			peak_low = MIN_RESET;
		end else begin
			ring_copy[next_slot] = item.sample;
			next_slot = (next_slot + 1) % RING;
			if (filled < RING)
				filled++;
			if (item.sample > peak_high)
				peak_high = item.sample;
			if (item.sample < peak_low)
				peak_low = item.sample;
			// A zero window counts as one; a window beyond the ring is capped.
			span = window_setting;
			if (span < 1)
				span = 1;
			if (span > RING)
				span = RING;
			if (filled >= span) begin
				total = 0;
				pos = next_slot;
				for (int k = 0; k < span; k++) begin
					pos = (pos + RING - 1) % RING;
					total += ring_copy[pos];
				end
				// Integer division truncates toward zero, as required.
				last_mean = total / span;
				fresh = 1'b1;
			end
		end
		summary.maximum = peak_high;
		summary.minimum = peak_low;
		summary.average = last_mean;
		summary.average_valid = fresh;
		return summary;
	endfunction

	function automatic in_item_t make_reading(logic cmd, int value);
		in_item_t item;
		item.command = cmd;
		item.sample = value[SAMPLE_W-1:0];
		return item;
	endfunction

	// Mostly samples, spread over extremes, a narrow band and the full range.
	function automatic in_item_t random_reading();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return make_reading(CMD_CLEAR, $urandom);
		else if (pick < 18)
			return make_reading(CMD_SAMPLE, ($urandom_range(1)) ? SAMPLE_MAX : SAMPLE_MIN);
		else if (pick < 55)
			return make_reading(CMD_SAMPLE, int'($urandom_range(4000)) - 2000);
		else if (pick < 65)
			return make_reading(CMD_SAMPLE, int'($urandom_range(6)) - 3);
		else
			return make_reading(CMD_SAMPLE, $urandom);
	endfunction

	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// Sender: predicts on acceptance, then offers the next pending item or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_summaries.push_back(track_reading(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_readings.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (holds_started != hold_requests) begin
			holds_started <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_summaries.size() == 0) begin
				$error("unexpected result: maximum %0d, minimum %0d, average %0d, valid %0d",
					out_item.maximum, out_item.minimum, out_item.average,
					out_item.average_valid);
				mismatch_count++;
			end else begin
				want = expected_summaries.pop_front();
				compare_field("maximum", want.maximum, out_item.maximum);
				compare_field("minimum", want.minimum, out_item.minimum);
				compare_field("average", want.average, out_item.average);
				compare_field("average_valid", want.average_valid, out_item.average_valid);
			end
		end
	end

	// Wait until every item is accepted and answered, then let the block settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_readings.size() != 0 || in_valid || expected_summaries.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[WIN_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		window_setting = value;
	endtask

	task automatic run_phase(int window, int send_pct, int stall_pct_v, int count);
		set_window(window);
		send_idle_pct = send_pct;
		stall_pct = stall_pct_v;
		repeat (count) pending_readings.push_back(random_reading());
		wait_idle();
	endtask

	// Stimulus sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset window of eight: all-negative start, extremes,
		// the first fresh mean, truncation toward zero and clears.
		pending_readings.push_back(make_reading(CMD_CLEAR, 0));
		pending_readings.push_back(make_reading(CMD_SAMPLE, -5));
		pending_readings.push_back(make_reading(CMD_SAMPLE, -100));
		pending_readings.push_back(make_reading(CMD_SAMPLE, SAMPLE_MIN));
		pending_readings.push_back(make_reading(CMD_SAMPLE, SAMPLE_MAX));
		pending_readings.push_back(make_reading(CMD_SAMPLE, 1));
		pending_readings.push_back(make_reading(CMD_SAMPLE, -1));
		pending_readings.push_back(make_reading(CMD_SAMPLE, 0));
		pending_readings.push_back(make_reading(CMD_SAMPLE, 3));
		pending_readings.push_back(make_reading(CMD_CLEAR, -1));
		repeat (8) pending_readings.push_back(make_reading(CMD_SAMPLE, SAMPLE_MIN));
		repeat (8) pending_readings.push_back(make_reading(CMD_SAMPLE, SAMPLE_MAX));
		pending_readings.push_back(make_reading(CMD_SAMPLE, -7));
		pending_readings.push_back(make_reading(CMD_CLEAR, SAMPLE_MAX));
		wait_idle();

		// Directed truncation check with a window of two: the mean of 0 and -1 truncates to 0.
		set_window(2);
		pending_readings.push_back(make_reading(CMD_SAMPLE, 0));
		pending_readings.push_back(make_reading(CMD_SAMPLE, -1));
		pending_readings.push_back(make_reading(CMD_SAMPLE, 1));
		wait_idle();

		run_phase(1, 0, 0, 250);
		run_phase(15, 75, 0, 250);
		run_phase(0, 0, 75, 250);
		run_phase(3, 13, 13, 250);

		// Long receiver hold-off while the sender keeps offering items.
		set_window(8);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		repeat (200) pending_readings.push_back(random_reading());
		wait_idle();

		run_phase(5, 13, 13, 150);
		for (int chunk = 0; chunk < 6; chunk++) begin
			case ($urandom_range(3))
				0: run_phase($urandom_range(15), 0, 0, 50);
				1: run_phase($urandom_range(15), 75, 0, 50);
				2: run_phase($urandom_range(15), 0, 75, 50);
				default: run_phase($urandom_range(15), 13, 13, 50);
			endcase
		end

		if (mismatch_count == 0 && expected_summaries.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Run limit.
	initial begin
		#(RUN_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

endmodule
